FILE: rtl/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define RDSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rdsc assertion failed");

// next-cycle implication, disabled while reset is low
`define RDSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rdsc assertion failed");

`endif

FILE: rtl/rdsc_pkg.sv
// shared types, constants and helpers of the radix digit string converter
// no dependencies; imported by rdsc_div, the top level and the testbench
package rdsc_pkg;

  // sizing
  localparam int MAX_RADIX   = 16;
  localparam int VALUE_BITS  = 64;
  localparam int NUM_SYMS    = 16;
  localparam int RADIX_W     = 5;
  localparam int DIGIT_W     = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
  localparam int SYM_IDX_W   = 4;

  // digit buffer: one entry per possible digit (radix two worst case)
  localparam int DIG_DEPTH   = VALUE_BITS;
  localparam int DIG_ADDR_W  = $clog2(DIG_DEPTH);

  // divider: quotient bits produced per cycle
  localparam int DIV_BPC     = 8;
  localparam int DIV_CYCLES  = (VALUE_BITS + DIV_BPC - 1) / DIV_BPC;
  localparam int DIV_W       = DIV_CYCLES * DIV_BPC;
  localparam int DIV_CNT_W   = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  // forbidden symbols
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // configuration register indexes
  localparam logic [1:0] CFG_IDX_RADIX    = 2'd0;
  localparam logic [1:0] CFG_IDX_SYMS_LOW = 2'd1;
  localparam logic [1:0] CFG_IDX_SYMS_HI  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_EMIT,
    ST_ERR
  } rdsc_state_t;

  // divider status back to the sequencer
  typedef struct packed {
    logic                 done;
    logic [DIV_W-1:0]     quot;
    logic [DIGIT_W-1:0]   rem;
  } rdsc_div_res_t;

endpackage

FILE: rtl/rdsc_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module rdsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/rdsc_div.sv
// iterative divider of the working value by the radix, DIV_BPC bits a cycle
// depends on rdsc_pkg
module rdsc_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [rdsc_pkg::DIV_W-1:0]      dividend,
  input  logic [rdsc_pkg::RADIX_W-1:0]    radix,
  output rdsc_pkg::rdsc_div_res_t         res
);
  import rdsc_pkg::*;

  logic [DIV_W-1:0]     sh_r, sh_nxt;
  logic [DIGIT_W-1:0]   rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 run_r;
  logic                 done_r;

  // restoring long division over DIV_BPC bits; remainder stays below radix
  always_comb begin
    logic [RADIX_W-1:0] t;
    logic [DIGIT_W-1:0] rem;
    logic [DIV_W-1:0]   sh;
    rem = rem_r;
    sh  = sh_r;
    for (int k = 0; k < DIV_BPC; k++) begin
      t  = RADIX_W'({rem, sh[DIV_W-1]});
      sh = {sh[DIV_W-2:0], 1'b0};
      if (t >= radix) begin
        rem   = DIGIT_W'(t - radix);
        sh[0] = 1'b1;
      end else begin
        rem = DIGIT_W'(t);
      end
    end
    sh_nxt  = sh;
    rem_nxt = rem;
  end

  // control: load on start, run DIV_CYCLES steps, pulse done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= dividend;
      rem_r <= '0;
    end else if (run_r) begin
      sh_r  <= sh_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign res.done = done_r;
  assign res.quot = sh_r;
  assign res.rem  = rem_r;

endmodule

FILE: rtl/radix_digit_string_converter.sv
// top level of the radix digit string converter: config registers, sequencer,
// alphabet check, digit buffer; depends on rdsc_pkg, rdsc_div, rdsc_ram
//
// A transaction starts when start is high and busy is low. The alphabet is
// checked first, one symbol a cycle. An invalid alphabet gives
// a single result with out_bad_alphabet set. Otherwise the value is divided
// by the radix repeatedly in the shared divider, the remainders go into a
// 64-entry digit buffer, and the digits are then read back most significant
// first, one result per cycle, out_last_digit marking the final one.
// Results appear for one cycle on out_strobe and cannot be stalled. busy
// stays high until the last result has been shown. Configuration writes
// are always accepted (cfg_ready is tied high) and must be made while busy
// is low.
module radix_digit_string_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_value,
  output logic        out_strobe,
  output logic [7:0]  out_digit_char,
  output logic        out_last_digit,
  output logic        out_bad_alphabet,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import rdsc_pkg::*;

  rdsc_state_t state_r, state_nxt;

  logic [RADIX_W-1:0]    radix_r;
  logic [63:0]           syms_low_r;
  logic [63:0]           syms_high_r;
  logic [7:0]            sym [NUM_SYMS];

  logic [DIV_W-1:0]      cur_r, cur_nxt;
  logic [RADIX_W-1:0]    chk_idx_r, chk_idx_nxt;
  logic [DIG_ADDR_W-1:0] n_r, n_nxt;
  logic [DIG_ADDR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic                  pend_r, pend_nxt;
  logic                  pend_last_r, pend_last_nxt;

  logic                  sym_bad;
  logic                  div_start;
  logic [DIV_W-1:0]      div_dividend;
  rdsc_div_res_t         div_res;
  logic                  ram_we;
  logic [DIGIT_W-1:0]    ram_rdata;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r     <= '0;
      syms_low_r  <= '0;
      syms_high_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_RADIX:    radix_r     <= cfg_data[RADIX_W-1:0];
        CFG_IDX_SYMS_LOW: syms_low_r  <= cfg_data;
        CFG_IDX_SYMS_HI:  syms_high_r <= cfg_data;
        default:          ;
      endcase
    end
  end

  // symbol table view
  always_comb begin
    for (int i = 0; i < NUM_SYMS; i++) begin
      if (i < 8) begin
        sym[i] = syms_low_r[i*8 +: 8];
      end else begin
        sym[i] = syms_high_r[(i-8)*8 +: 8];
      end
    end
  end

  // alphabet check of one symbol: a sign character, or equal to a later symbol in use
  always_comb begin
    logic [7:0] a;
    a       = sym[chk_idx_r[SYM_IDX_W-1:0]];
    sym_bad = (a == CH_PLUS) || (a == CH_MINUS);
    for (int j = 0; j < NUM_SYMS; j++) begin
      if ((RADIX_W'(j) > chk_idx_r) && (RADIX_W'(j) < radix_r) && (sym[j] == a)) begin
        sym_bad = 1'b1;
      end
    end
  end

  // shared divider
  rdsc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .radix    (radix_r),
    .res      (div_res)
  );

  // digit buffer
  assign ram_we = (state_r == ST_DIV) && div_res.done;

  rdsc_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (DIG_DEPTH)
  ) u_dig_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (n_r),
    .wdata (div_res.rem),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  // sequencer next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    chk_idx_nxt   = chk_idx_r;
    n_nxt         = n_r;
    rd_ptr_nxt    = rd_ptr_r;
    pend_nxt      = 1'b0;
    pend_last_nxt = pend_last_r;
    div_start     = 1'b0;
    div_dividend  = cur_r;
    case (state_r)
      ST_IDLE: begin
        if (start && !busy) begin
          cur_nxt     = DIV_W'(in_value[VALUE_BITS-1:0]);
          chk_idx_nxt = '0;
          n_nxt       = '0;
          if ((radix_r < RADIX_W'(2)) || (radix_r > RADIX_W'(MAX_RADIX))) begin
            state_nxt = ST_ERR;
          end else begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (sym_bad) begin
          state_nxt = ST_ERR;
        end else if (chk_idx_r == radix_r - 1'b1) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end else begin
          chk_idx_nxt = chk_idx_r + 1'b1;
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          n_nxt = n_r + 1'b1;
          if ((div_res.quot == '0) || (n_r == DIG_ADDR_W'(DIG_DEPTH - 1))) begin
            rd_ptr_nxt = n_r;
            state_nxt  = ST_EMIT;
          end else begin
            cur_nxt      = div_res.quot;
            div_dividend = div_res.quot;
            div_start    = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        pend_nxt      = 1'b1;
        pend_last_nxt = (rd_ptr_r == '0);
        if (rd_ptr_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          rd_ptr_nxt = rd_ptr_r - 1'b1;
        end
      end
      ST_ERR: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    chk_idx_r   <= chk_idx_nxt;
    n_r         <= n_nxt;
    rd_ptr_r    <= rd_ptr_nxt;
    pend_last_r <= pend_last_nxt;
  end

  // result ports: digit read in the cycle after its buffer address, or the error
  assign busy             = (state_r != ST_IDLE) || pend_r;
  assign out_strobe       = pend_r || (state_r == ST_ERR);
  assign out_bad_alphabet = (state_r == ST_ERR);
  assign out_last_digit   = (state_r == ST_ERR) || pend_last_r;
  assign out_digit_char   = pend_r ? sym[SYM_IDX_W'(ram_rdata)] : 8'h00;

endmodule

FILE: rtl/rdsc_checker.sv
// port-level checker of the radix digit string converter, bound to the top
// depends on assert_macros.svh
`include "assert_macros.svh"

module rdsc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_strobe,
  input logic [7:0] out_digit_char,
  input logic       out_last_digit,
  input logic       out_bad_alphabet
);

  // an error result is the only and final one, and carries no symbol
  `RDSC_ASSERT_IMP(a_err_result, clk, rst_n, out_strobe && out_bad_alphabet, out_last_digit && (out_digit_char == 8'h00))

  // an accepted transaction makes the block busy
  `RDSC_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy)

  // no result outside a transaction
  `RDSC_ASSERT_IMP(a_no_idle_result, clk, rst_n, !busy, !out_strobe)

  // the final result ends the burst
  `RDSC_ASSERT_NXT(a_last_ends, clk, rst_n, out_strobe && out_last_digit, !out_strobe)

endmodule

bind radix_digit_string_converter rdsc_checker u_rdsc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_strobe       (out_strobe),
  .out_digit_char   (out_digit_char),
  .out_last_digit   (out_last_digit),
  .out_bad_alphabet (out_bad_alphabet)
);

FILE: sim/tb_radix_digit_string_converter.sv
`timescale 1ns / 100ps
// testbench for radix_digit_string_converter: directed and random conversions
// checked digit by digit against a behavioral predictor; depends on rdsc_pkg and the rtl

module tb_radix_digit_string_converter;
  import rdsc_pkg::*;

  localparam int         CLK_HALF       = 6;
  localparam int         CYCLE_LIMIT    = 1_000_000;
  localparam int         MAX_REPORTS    = 10;
  localparam int         TAIL_CYCLES    = 40;
  localparam int         RANDOM_PHASES  = 11;
  localparam int         PHASE_ITEMS    = 20;
  localparam logic [1:0] CFG_IDX_UNUSED = 2'd3;

  // one result transaction as the block shows it
  typedef struct packed {
    logic [7:0] digit_char;
    logic       last_digit;
    logic       bad_alphabet;
  } digit_rec_t;

  // ways a random alphabet can be broken
  typedef enum int {
    BRK_NONE,
    BRK_LOW_RADIX,
    BRK_HIGH_RADIX,
    BRK_DUPLICATE,
    BRK_PLUS,
    BRK_MINUS
  } alpha_fault_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [63:0] in_value;
  logic        out_strobe;
  logic [7:0]  out_digit_char;
  logic        out_last_digit;
  logic        out_bad_alphabet;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  // predictor copy of the configuration
  logic [4:0]  mdl_radix;
  logic [63:0] mdl_syms_low;
  logic [63:0] mdl_syms_high;

  digit_rec_t  pending_digits[$];
  bit          gaps_on;
  int          error_count;
  int          items_sent;
  int          digits_seen;
  int          bad_results_seen;
  int          alphabets_written;
  int          cycle_count;

  radix_digit_string_converter u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_value         (in_value),
    .out_strobe       (out_strobe),
    .out_digit_char   (out_digit_char),
    .out_last_digit   (out_last_digit),
    .out_bad_alphabet (out_bad_alphabet),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d digits outstanding", cycle_count,
               pending_digits.size());
      $display("simulation failed");
      $finish;
    end
  end

  function automatic void note_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("mismatch: %s", msg);
  endfunction

  // symbol byte for digit d from the configured alphabet
  function automatic logic [7:0] symbol_for(input int d);
    logic [127:0] sym_bank;
    sym_bank = {mdl_syms_high, mdl_syms_low};
    return sym_bank[d*8 +: 8];
  endfunction

  // radix in range, used symbols distinct and not a sign character
  function automatic bit alphabet_is_valid();
    logic [7:0] a;
    if (mdl_radix < 2 || mdl_radix > MAX_RADIX) return 1'b0;
    for (int i = 0; i < mdl_radix; i++) begin
      a = symbol_for(i);
      if (a == CH_PLUS || a == CH_MINUS) return 1'b0;
      for (int j = i + 1; j < mdl_radix; j++)
        if (a == symbol_for(j)) return 1'b0;
    end
    return 1'b1;
  endfunction

  // expected digit transactions for one value, most significant first
  function automatic void convert_to_digits(input logic [63:0] value);
    logic [3:0]  rems [64];
    logic [63:0] rest;
    logic [63:0] base;
    int          n;
    digit_rec_t  rec;
    if (!alphabet_is_valid()) begin
      rec.digit_char   = 8'h00;
      rec.last_digit   = 1'b1;
      rec.bad_alphabet = 1'b1;
      pending_digits.push_back(rec);
      return;
    end
    rest = value & ({64{1'b1}} >> (64 - VALUE_BITS));
    base = 64'(mdl_radix);
    n = 0;
    do begin
      rems[n] = 4'(rest % base);
      rest = rest / base;
      n++;
    end while (rest != 0 && n < 64);
    for (int k = 0; k < n; k++) begin
      rec.digit_char   = symbol_for(rems[n-1-k]);
      rec.last_digit   = (k == n - 1);
      rec.bad_alphabet = 1'b0;
      pending_digits.push_back(rec);
    end
  endfunction

  // result checker: each strobe against the oldest expectation
  always @(posedge clk) begin : check_digits
    digit_rec_t want;
    if (rst_n && out_strobe) begin
      if (pending_digits.size() == 0) begin
        note_mismatch($sformatf("unexpected result char %02h last %0b bad %0b",
                                out_digit_char, out_last_digit, out_bad_alphabet));
      end else begin
        want = pending_digits.pop_front();
        if (out_digit_char !== want.digit_char || out_last_digit !== want.last_digit ||
            out_bad_alphabet !== want.bad_alphabet)
          note_mismatch($sformatf(
            "item %0d: expected char %02h last %0b bad %0b, got char %02h last %0b bad %0b",
            items_sent, want.digit_char, want.last_digit, want.bad_alphabet,
            out_digit_char, out_last_digit, out_bad_alphabet));
        if (want.bad_alphabet) bad_results_seen++;
        else digits_seen++;
      end
    end
  end

  // idle length before a start, mostly short with a few long ones
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // one input transaction; start stays high when the next one follows at once
  task automatic send_value(input logic [63:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (busy);
    convert_to_digits(value);
    items_sent++;
  endtask

  // lower start and wait until every expected digit is out and the block is idle
  task automatic drain_results();
    start <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // one config transaction; valid is left high for a following write
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_IDX_RADIX:    mdl_radix     = data[4:0];
      CFG_IDX_SYMS_LOW: mdl_syms_low  = data;
      CFG_IDX_SYMS_HI:  mdl_syms_high = data;
      default: ;
    endcase
  endtask

  // full alphabet reload between phases, junk in the unused radix bits
  task automatic set_alphabet(input logic [4:0] rdx, input logic [63:0] lo,
                              input logic [63:0] hi);
    logic [63:0] radix_word;
    drain_results();
    radix_word = {$urandom, $urandom};
    radix_word[4:0] = rdx;
    write_reg(CFG_IDX_RADIX, radix_word);
    write_reg(CFG_IDX_SYMS_LOW, lo);
    write_reg(CFG_IDX_SYMS_HI, hi);
    cfg_valid <= 1'b0;
    alphabets_written++;
  endtask

  // random distinct symbols for the used digits, random junk above them
  function automatic void make_alphabet(input int rdx, output logic [127:0] bank);
    logic [7:0] b;
    bit         clash;
    bank = {$urandom, $urandom, $urandom, $urandom};
    for (int i = 0; i < rdx; i++) begin
      do begin
        b = 8'($urandom_range(0, 255));
        clash = (b == CH_PLUS || b == CH_MINUS);
        for (int j = 0; j < i; j++)
          if (bank[j*8 +: 8] == b) clash = 1'b1;
      end while (clash);
      bank[i*8 +: 8] = b;
    end
  endfunction

  task automatic random_alphabet(input alpha_fault_t fault);
    logic [127:0] bank;
    int           rdx;
    int           i;
    int           j;
    case ($urandom_range(0, 9))
      0, 1:    rdx = 2;
      2, 3:    rdx = MAX_RADIX;
      default: rdx = $urandom_range(3, MAX_RADIX - 1);
    endcase
    make_alphabet(rdx, bank);
    i = $urandom_range(0, rdx - 2);
    j = $urandom_range(i + 1, rdx - 1);
    case (fault)
      BRK_LOW_RADIX:  rdx = $urandom_range(0, 1);
      BRK_HIGH_RADIX: rdx = $urandom_range(MAX_RADIX + 1, 31);
      BRK_DUPLICATE:  bank[j*8 +: 8] = bank[i*8 +: 8];
      BRK_PLUS:       bank[i*8 +: 8] = CH_PLUS;
      BRK_MINUS:      bank[j*8 +: 8] = CH_MINUS;
      default: ;
    endcase
    set_alphabet(5'(rdx), bank[63:0], bank[127:64]);
  endtask

  // values of every length, plus the two extremes
  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = '1;
      2, 3:    v = v >> $urandom_range(0, 63);
      4:       v = v >> $urandom_range(56, 63);
      default: ;
    endcase
    return v;
  endfunction

  // reset alphabet has radix zero: every value gives the error transaction
  task automatic test_reset_alphabet();
    send_value('0);
    send_value('1);
  endtask

  // decimal with ascii digits, including the longest decimal string
  task automatic test_decimal();
    set_alphabet(5'd10, 64'h3736_3534_3332_3130, 64'hFFFF_FFFF_FFFF_3938);
    send_value(64'd0);
    send_value(64'd9);
    send_value(64'd10);
    send_value('1);
    send_value(64'h8000_0000_0000_0000);
  endtask

  // write to an index past the register list leaves the alphabet alone
  task automatic test_unused_index();
    drain_results();
    write_reg(CFG_IDX_UNUSED, {$urandom, $urandom});
    cfg_valid <= 1'b0;
    send_value(64'd12345);
  endtask

  // binary: up to 64 digits; unused bytes hold repeats and sign characters
  task automatic test_binary();
    set_alphabet(5'd2, 64'h2B2B_2D2D_3131_3130, 64'h2D2B_3130_2D2B_3130);
    send_value('1);
    send_value(64'd1);
    send_value(64'h8000_0000_0000_0001);
  endtask

  // full sixteen symbol alphabet
  task automatic test_hex();
    set_alphabet(5'd16, 64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938);
    send_value('1);
    send_value(64'h0123_4567_89AB_CDEF);
    send_value(64'hF);
  endtask

  // a zero byte is an ordinary symbol
  task automatic test_zero_symbol();
    set_alphabet(5'd3, 64'h0000_0000_0080_FF00, 64'h0);
    send_value(64'd0);
    send_value(64'd8);
    send_value('1);
  endtask

  // radix out of range, repeated symbol, and sign characters in the alphabet
  task automatic test_bad_alphabets();
    set_alphabet(5'd1, 64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938);
    send_value(64'd5);
    set_alphabet(5'd17, 64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938);
    send_value(64'd5);
    set_alphabet(5'd31, 64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938);
    send_value('1);
    set_alphabet(5'd16, 64'h3736_3534_3332_3130, 64'h3045_4443_4241_3938);
    send_value(64'd100);
    set_alphabet(5'd16, 64'h3736_3534_3332_312B, 64'h4645_4443_4241_3938);
    send_value(64'd0);
    set_alphabet(5'd16, 64'h3736_3534_3332_3130, 64'h2D45_4443_4241_3938);
    send_value(64'd7);
  endtask

  // random phases: mostly valid alphabets, a couple broken, some without idling
  task automatic test_random_conversions();
    alpha_fault_t fault;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 3 || p == 8) fault = alpha_fault_t'($urandom_range(BRK_LOW_RADIX, BRK_MINUS));
      else fault = BRK_NONE;
      random_alphabet(fault);
      gaps_on = (p % 4 != 1);
      for (int k = 0; k < PHASE_ITEMS; k++) send_value(pick_value());
    end
    gaps_on = 1'b1;
  endtask

  // main sequence
  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_value      = '0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_IDX_RADIX;
    cfg_data      = '0;
    mdl_radix     = '0;
    mdl_syms_low  = '0;
    mdl_syms_high = '0;
    gaps_on       = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_alphabet();
    test_decimal();
    test_unused_index();
    test_binary();
    test_hex();
    test_zero_symbol();
    test_bad_alphabets();
    test_random_conversions();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_digits.size() != 0)
      note_mismatch($sformatf("%0d expected digits never arrived", pending_digits.size()));

    $display("converted %0d values under %0d alphabets in %0d cycles", items_sent,
             alphabets_written, cycle_count);
    $display("checked %0d digit transactions and %0d alphabet errors, %0d mismatches",
             digits_seen, bad_results_seen, error_count);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
